FILE: hw/rtl/asc_pkg.sv
package asc_pkg;

  // Sample formats
  localparam int unsigned FRACTION_BITS = 20;
  localparam int unsigned IN_W          = 24;
  localparam int unsigned OUT_W         = 21;

  // Register stages from the input beat to the output beat
  localparam int unsigned NSTG = 7;

  // tanh table: TANH_SEGMENTS linear segments over [0,8), power of two
  localparam int unsigned TANH_SEGMENTS = 256;
  localparam int unsigned SEG_LOG2      = $clog2(TANH_SEGMENTS);

  // Q30 values run from 0 to 1.0 inclusive
  localparam int unsigned Q30_W = 31;
  localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(64'd1 << 30);

  // Knee and the headroom above it, FRACTION_BITS fraction bits
  localparam logic [63:0] ONE   = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] KNEE  = (64'd95 * ONE + 64'd50) / 64'd100;
  localparam logic [63:0] DELTA = ONE - KNEE;
  localparam int unsigned DELTA_W = $clog2(DELTA + 64'd1);

  // Excess scaled by 20 fits in five more bits than the magnitude
  localparam int unsigned X_W = IN_W + 5;

  // Segment index sits above INTERP_SH fraction bits of x
  localparam int unsigned INTERP_SH = FRACTION_BITS + 3 - SEG_LOG2;
  localparam int unsigned PROD_W    = Q30_W + INTERP_SH;
  localparam int unsigned MUL_W     = DELTA_W + Q30_W;

  typedef logic [Q30_W-1:0] q30_t;
  typedef q30_t tanh_tab_t [0:TANH_SEGMENTS];

  // Restoring long division, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(8*i/N) in Q30 as (1-p)/(1+p), p = exp(-16/N)^i
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    y    = ((64'd16 << 30) + 64'(TANH_SEGMENTS / 2)) / 64'(TANH_SEGMENTS);
    term = 64'd1 << 30;
    e    = 64'd1 << 30;
    p    = 64'd1 << 30;
    // Taylor series of exp(-y) with truncating steps
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * y) >> 30, 64'(k));
      if ((k % 2) == 1) begin
        e = (e >= term) ? e - term : 64'd0;
      end else begin
        e = e + term;
      end
    end
    for (int i = 0; i <= TANH_SEGMENTS; i++) begin
      den    = (64'd1 << 30) + p;
      num    = ((64'd1 << 30) - p) << 30;
      tab[i] = Q30_W'(udiv64(num + (den >> 1), den));
      p      = (p * e + (64'd1 << 29)) >> 30;
      if (p > (64'd1 << 30)) begin
        p = 64'd1 << 30;
      end
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

FILE: hw/rtl/audio_soft_clipper_top.sv
// Soft clipper for one audio sample per beat. sample_in_i is signed with 20
// fraction bits and about +/-8 of headroom; magnitudes up to the 0.95 knee
// pass unchanged, larger ones become knee + 0.05*tanh(20*excess) with the
// input's sign, so sample_out_o always stays below full scale. was_shaped_o
// flags shaped beats. tanh comes from a 256-segment constant table with
// linear interpolation, exactly 1.0 at 8 and above. The block is a
// seven-stage pipeline: it takes one beat per cycle, and each result passes
// through every stage register before it is offered on the output. A
// stall on the output holds every stage in place, so in_ready_o follows
// out_ready_i whenever the output register is full.
module audio_soft_clipper_top
  import asc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] sample_out_o,
  output logic                    was_shaped_o
);

  // Pipeline advance: whole pipe moves unless the output beat is stuck
  logic adv;
  logic [NSTG-1:0] vld_q, vld_d;

  assign adv        = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    vld_d = {vld_q[NSTG-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Side data that rides along the pipeline stages
  logic [NSTG-2:0]  neg_q;
  logic [OUT_W-1:0] raw_q [NSTG-1];
  logic [NSTG-2:1]  shp_q;

  // Stage 1: magnitude and sign
  logic [IN_W-1:0] mag_d, mag_q;
  assign mag_d = sample_in_i[IN_W-1] ? (~sample_in_i + IN_W'(1)) : sample_in_i;

  // Stage 2: knee compare and scaled excess
  logic [IN_W-1:0] exc;
  logic [X_W-1:0]  x_d, x_q;
  logic            shp_d;
  assign shp_d = mag_q > IN_W'(KNEE);
  assign exc   = mag_q - IN_W'(KNEE);
  assign x_d   = X_W'(exc) * X_W'(20);

  // Stage 3: table lookup of the segment end points
  logic [SEG_LOG2-1:0]  seg_idx;
  logic [SEG_LOG2:0]    tab_lo, tab_hi;
  logic                 sat_d;
  q30_t                 a_d, b_d;
  q30_t                 a3_q, b3_q;
  logic [INTERP_SH-1:0] xf_q;
  logic [4:3]           sat_q;
  assign seg_idx = x_q[INTERP_SH +: SEG_LOG2];
  assign sat_d   = |(x_q >> (INTERP_SH + SEG_LOG2));
  assign tab_lo  = {1'b0, seg_idx};
  assign tab_hi  = tab_lo + (SEG_LOG2 + 1)'(1);
  assign a_d     = TANH_TAB[tab_lo];
  assign b_d     = TANH_TAB[tab_hi];

  // Stage 4: slope times position inside the segment
  logic              up_d, up_q;
  q30_t              diff;
  logic [PROD_W-1:0] prod_d, prod_q;
  q30_t              a4_q;
  assign up_d   = b3_q >= a3_q;
  assign diff   = up_d ? (b3_q - a3_q) : (a3_q - b3_q);
  assign prod_d = PROD_W'(diff) * PROD_W'(xf_q);

  // Stage 5: interpolated tanh, rounded half up
  q30_t            step;
  q30_t            t_d, t_q;
  assign step    = Q30_W'(({1'b0, prod_q} + ((PROD_W + 1)'(1) << (INTERP_SH - 1)))
                          >> INTERP_SH);
  always_comb begin
    if (sat_q[4]) begin
      t_d = Q30_ONE;
    end else if (up_q) begin
      t_d = a4_q + step;
    end else begin
      t_d = a4_q - step;
    end
  end

  // Stage 6: scale by the headroom above the knee
  logic [MUL_W-1:0] m_d, m_q;
  assign m_d = MUL_W'(DELTA) * MUL_W'(t_q);

  // Stage 7: add knee, saturate, restore sign, or pass the raw sample through
  logic [MUL_W:0]   m_rnd;
  logic [OUT_W-1:0] res, res_sat, shaped_val;
  logic [OUT_W-1:0] out_d, out_q;
  logic             shp_out_q;
  assign m_rnd      = ({1'b0, m_q} + ((MUL_W + 1)'(1) << 29)) >> 30;
  assign res        = OUT_W'(KNEE) + OUT_W'(m_rnd);
  assign res_sat    = (res >= OUT_W'(ONE)) ? OUT_W'(ONE - 64'd1) : res;
  assign shaped_val = neg_q[5] ? (~res_sat + OUT_W'(1)) : res_sat;
  assign out_d      = shp_q[5] ? shaped_val : raw_q[5];

  // Payload registers, enabled with the pipe
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q[0]  <= sample_in_i[IN_W-1];
      raw_q[0]  <= sample_in_i[OUT_W-1:0];
      mag_q     <= mag_d;
      for (int s = 1; s < NSTG - 1; s++) begin
        neg_q[s] <= neg_q[s-1];
        raw_q[s] <= raw_q[s-1];
      end
      shp_q[1]  <= shp_d;
      for (int s = 2; s < NSTG - 1; s++) begin
        shp_q[s] <= shp_q[s-1];
      end
      x_q       <= x_d;
      a3_q      <= a_d;
      b3_q      <= b_d;
      xf_q      <= x_q[INTERP_SH-1:0];
      sat_q[3]  <= sat_d;
      sat_q[4]  <= sat_q[3];
      up_q      <= up_d;
      prod_q    <= prod_d;
      a4_q      <= a3_q;
      t_q       <= t_d;
      m_q       <= m_d;
      out_q     <= out_d;
      shp_out_q <= shp_q[5];
    end
  end

  assign out_valid_o  = vld_q[NSTG-1];
  assign sample_out_o = out_q;
  assign was_shaped_o = shp_out_q;

endmodule

FILE: tb/sv/audio_soft_clipper_top_test.sv
module audio_soft_clipper_top_test import asc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Sample scale, own copies of the knee and the table reach
  localparam longint FULL_SCALE  = longint'(1) << FRACTION_BITS;
  localparam longint KNEE_MAG    = (95 * FULL_SCALE + 50) / 100;
  localparam longint TABLE_REACH = (8 * FULL_SCALE + 19) / 20;
  localparam longint IN_MAX      = (longint'(1) << (IN_W - 1)) - 1;

  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic signed [IN_W-1:0]  origin;
    logic signed [OUT_W-1:0] level;
    logic                    shaped;
  } clip_beat_t;

  // Predicts each clipped beat and checks the output stream in order
  class clip_scoreboard;
    longint unsigned tanh_q30_tab [0:TANH_SEGMENTS];
    clip_beat_t      expected_clips[$];
    int              error_count;

    function new();
      error_count = 0;
      build_tanh_table();
    endfunction

    // tanh(8*i/N) in Q30 from (1-p)/(1+p), p stepping by exp(-16/N)
    function void build_tanh_table();
      longint unsigned y, term, e, p, num, den;
      y    = ((64'd16 << 30) + TANH_SEGMENTS / 2) / TANH_SEGMENTS;
      term = 64'd1 << 30;
      e    = 64'd1 << 30;
      p    = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * y) >> 30) / k;
        if (k % 2 == 1) begin
          e = (e >= term) ? e - term : 64'd0;
        end else begin
          e = e + term;
        end
      end
      for (int i = 0; i <= TANH_SEGMENTS; i++) begin
        den = (64'd1 << 30) + p;
        num = ((64'd1 << 30) - p) << 30;
        tanh_q30_tab[i] = (num + den / 2) / den;
        p = (p * e + (64'd1 << 29)) >> 30;
        if (p > (64'd1 << 30)) begin
          p = 64'd1 << 30;
        end
      end
    endfunction

    // Linear interpolation between table points, exactly 1.0 past the end
    function longint unsigned tanh_interp(longint unsigned x);
      int unsigned     sh;
      longint unsigned pos, idx, frac, half, a, b;
      sh   = FRACTION_BITS + 3;
      pos  = x * TANH_SEGMENTS;
      idx  = pos >> sh;
      frac = pos & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (idx >= TANH_SEGMENTS) begin
        return 64'd1 << 30;
      end
      a = tanh_q30_tab[idx];
      b = tanh_q30_tab[idx + 1];
      if (b >= a) begin
        return a + (((b - a) * frac + half) >> sh);
      end
      return a - (((a - b) * frac + half) >> sh);
    endfunction

    function clip_beat_t predict_clip(logic signed [IN_W-1:0] s);
      longint          sx;
      longint unsigned mag, res, delta;
      logic            neg;
      clip_beat_t      r;
      sx       = longint'(s);
      neg      = s[IN_W-1];
      mag      = neg ? -sx : sx;
      delta    = FULL_SCALE - KNEE_MAG;
      r.origin = s;
      if (mag <= KNEE_MAG) begin
        r.level  = OUT_W'(neg ? 64'd0 - mag : mag);
        r.shaped = 1'b0;
        return r;
      end
      res = KNEE_MAG + ((delta * tanh_interp((mag - KNEE_MAG) * 20) + (64'd1 << 29)) >> 30);
      // full-scale shaped result saturates just below one
      if (res >= FULL_SCALE) begin
        res = FULL_SCALE - 1;
      end
      r.level  = OUT_W'(neg ? 64'd0 - res : res);
      r.shaped = 1'b1;
      return r;
    endfunction

    function void note_sample(logic signed [IN_W-1:0] s);
      expected_clips.push_back(predict_clip(s));
    endfunction

    function void check_beat(logic signed [OUT_W-1:0] level, logic shaped);
      clip_beat_t want;
      if (expected_clips.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected beat sample_out=%0d was_shaped=%0b",
                   $realtime, level, shaped);
        end
        return;
      end
      want = expected_clips.pop_front();
      if (level !== want.level || shaped !== want.shaped) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: sample_in=%0d sample_out exp %0d got %0d, was_shaped exp %0b got %0b",
                   $realtime, want.origin, want.level, level, want.shaped, shaped);
        end
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] sample_out_o;
  logic                    was_shaped_o;

  bit tx_gaps      = 1'b1;
  bit rx_steady    = 1'b0;
  bit hold_off_req = 1'b0;

  clip_scoreboard sb = new();
  longint directed_vals [22];
  int     idle_cycles = 0;

  audio_soft_clipper_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .was_shaped_o (was_shaped_o)
  );

  always #6 clk_i = ~clk_i;

  // Offer one sample, with random idle cycles ahead of it while tx_gaps is set, and wait for the beat
  task automatic send_sample(input logic signed [IN_W-1:0] s);
    while (tx_gaps && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly near the knee and inside the table, some large and some raw
  function automatic logic signed [IN_W-1:0] random_sample();
    longint      mag;
    int unsigned pick;
    bit          neg;
    pick = $urandom_range(99);
    neg  = 1'($urandom_range(1));
    if (pick < 30) begin
      mag = KNEE_MAG + longint'($urandom_range(4000)) - 2000;
    end else if (pick < 60) begin
      mag = KNEE_MAG + longint'($urandom_range(1, 32'(TABLE_REACH + 2000)));
    end else if (pick < 75) begin
      mag = longint'($urandom_range(32'(IN_MAX + 1)));
    end else begin
      return IN_W'($urandom);
    end
    if (!neg && mag > IN_MAX) begin
      mag = IN_MAX;
    end
    return IN_W'(neg ? -mag : mag);
  endfunction

  // Receiver: random stalls, a steady stretch and one long hold-off
  initial begin : rx_driver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (hold_left > 0) begin
          out_ready_i <= 1'b0;
          hold_left--;
        end else if (hold_off_req) begin
          hold_off_req = 1'b0;
          hold_left    = HOLD_CYCLES;
          out_ready_i <= 1'b0;
        end else if (rx_steady) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= ($urandom_range(99) >= 30);
        end
      end
    end
  end

  // Beat monitor on both sides plus a no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_sample(sample_in_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_beat(sample_out_o, was_shaped_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $realtime, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    directed_vals = '{
      0, 1, -1,
      KNEE_MAG - 1, KNEE_MAG, KNEE_MAG + 1, -KNEE_MAG, -(KNEE_MAG + 1),
      KNEE_MAG + 8192, KNEE_MAG + 8193, -(KNEE_MAG + 8192),
      FULL_SCALE, -FULL_SCALE,
      KNEE_MAG + TABLE_REACH - 1, KNEE_MAG + TABLE_REACH, -(KNEE_MAG + TABLE_REACH),
      IN_MAX, -IN_MAX, -(IN_MAX + 1),
      longint'(24'h555555), -longint'(24'h555556), 2 * FULL_SCALE
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // knee edges, segment boundary, table end, extremes
    foreach (directed_vals[i]) begin
      send_sample(IN_W'(directed_vals[i]));
    end
    repeat (600) send_sample(random_sample());

    // back-to-back stretch, no idling on either side
    tx_gaps   = 1'b0;
    rx_steady = 1'b1;
    repeat (400) send_sample(random_sample());
    rx_steady = 1'b0;

    // receiver holds off while samples keep coming, pipeline backs up
    hold_off_req = 1'b1;
    repeat (300) send_sample(random_sample());

    // sender pauses until the pipeline has drained
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_clips.size() != 0);
    tx_gaps = 1'b1;
    repeat (700) send_sample(random_sample());

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_clips.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.expected_clips.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
